// ===== rtl/core/sblt_pkg.sv =====
// Package for the spectrum band level tracker: shared types, constants
// and helper functions. No dependencies.
`timescale 1ns / 1ps
package sblt_pkg;

  localparam int NUM_BINS = 512;
  localparam int BANDS = 5;
  localparam int CNT_W = 10;
  localparam int SUM_W = 48;
  localparam int LVL_W = 24;
  localparam int CUT_W = 9;
  localparam int GAIN_W = 11;
  localparam int BAND_W = 3;
  localparam int DIV_STEPS = SUM_W;

  // Averages and targets clamp to TGT_W bits; any clamped value already
  // drives the level into saturation.
  localparam int TGT_W = 28;
  localparam int SCALE_SH = 30;
  localparam int RECIP_SH = 32;
  localparam logic [31:0] RECIP10 = 32'd429496730;  // ceil(2^32 / 10)

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [LVL_W-1:0] LVL_MAX = '1;

  localparam logic [2:0] REG_GAIN = 3'd0;
  localparam logic [2:0] REG_SUB = 3'd1;
  localparam logic [2:0] REG_LOW_MID = 3'd2;
  localparam logic [2:0] REG_MID = 3'd3;
  localparam logic [2:0] REG_HIGH_MID = 3'd4;

  typedef struct packed {
    logic [15:0] bin_magnitude;
    logic        last_bin;
  } in_item_t;

  typedef struct packed {
    logic [LVL_W-1:0] sub_bass_level;
    logic [LVL_W-1:0] low_mid_level;
    logic [LVL_W-1:0] mid_level;
    logic [LVL_W-1:0] high_mid_level;
    logic [LVL_W-1:0] treble_level;
  } out_item_t;

  typedef struct packed {
    logic [2:0]        index;
    logic [31:0]       data;
  } cfg_req_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic             mul_a;     // stage 1 of bin weighting
    logic             mul_b;     // stage 2 of bin weighting
    logic             acc;       // accumulate weighted bin
    logic             div_load;  // load divider for band
    logic             div_step;  // one restoring division step
    logic             tgt_calc;  // compute band target
    logic             lvl_calc;  // compute new level
    logic             clr_frame; // clear sums and counts
    logic [BAND_W-1:0] band;
  } cmd_t;

  // Band weight over ten in Q30, rounded up; exact enough for averages
  // below 2^TGT_W.
  function automatic logic [32:0] band_scale(input logic [BAND_W-1:0] b);
    case (b)
      3'd0: band_scale = 33'd1073741824;
      3'd1: band_scale = 33'd1932735284;
      3'd2: band_scale = 33'd2684354560;
      3'd3: band_scale = 33'd4294967296;
      default: band_scale = 33'd6442450944;
    endcase
  endfunction

endpackage

// ===== rtl/core/sblt_ctrl.sv =====
// Controller for the band level tracker: sequences bin weighting and the
// per-frame band division. Depends on sblt_pkg.
`timescale 1ns / 1ps
module sblt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          last_bin,
  output logic          busy,
  output logic          done,
  output sblt_pkg::cmd_t cmd
);
  import sblt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MULB = 7'b0000010,
    S_ACC  = 7'b0000100,
    S_DLD  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_TGT  = 7'b0100000,
    S_LVL  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic last_q;
  logic [BAND_W-1:0] band, band_next;
  logic [5:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      band <= '0;
      step <= '0;
      last_q <= 1'b0;
    end else begin
      state <= state_next;
      band <= band_next;
      step <= step_next;
      if (start && state == S_IDLE) last_q <= last_bin;
    end
  end

  always_comb begin
    state_next = state;
    band_next = band;
    step_next = step;
    cmd = '0;
    cmd.band = band;
    done = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.mul_a = 1'b1;
          state_next = S_MULB;
        end
      end
      S_MULB: begin
        cmd.mul_b = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        band_next = '0;
        state_next = last_q ? S_DLD : S_IDLE;
      end
      S_DLD: begin
        cmd.div_load = 1'b1;
        step_next = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next = step + 6'd1;
        if (step == 6'(DIV_STEPS - 1)) state_next = S_TGT;
      end
      S_TGT: begin
        cmd.tgt_calc = 1'b1;
        state_next = S_LVL;
      end
      S_LVL: begin
        cmd.lvl_calc = 1'b1;
        if (band == 3'(BANDS - 1)) begin
          cmd.clr_frame = 1'b1;
          done = 1'b1;
          state_next = S_IDLE;
        end else begin
          band_next = band + 3'd1;
          state_next = S_DLD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> state == S_MULB) else $error("no start");
  a_done_last_band: assert property (@(posedge clk) disable iff (rst)
    done |-> band == 3'(BANDS - 1)) else $error("done early");
  a_band_range: assert property (@(posedge clk) disable iff (rst)
    band < 3'(BANDS)) else $error("band range");
endmodule

// ===== rtl/core/sblt_dp.sv =====
// Datapath for the band level tracker: bin weighting, band sums, serial
// divider and level smoothing. Depends on sblt_pkg.
`timescale 1ns / 1ps
module sblt_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  sblt_pkg::in_item_t in_item,
  input  logic               cfg_we,
  input  sblt_pkg::cfg_req_t cfg_req,
  input  sblt_pkg::cmd_t     cmd,
  output sblt_pkg::out_item_t levels
);
  import sblt_pkg::*;

  logic [GAIN_W-1:0] audio_gain;
  logic [CUT_W-1:0] sub_cutoff, low_mid_cutoff, mid_cutoff, high_mid_cutoff;

  logic [CNT_W-1:0] bin_counter;
  logic [SUM_W-1:0] band_sums [BANDS];
  logic [CNT_W-1:0] band_counts [BANDS];
  logic [LVL_W-1:0] band_levels [BANDS];

  logic [CNT_W-1:0] idx_q;
  logic [BAND_W-1:0] pick_q;
  logic [31:0] prod_a;   // mag * gain * 25 (16+11+5 bits)
  logic [16:0] tilt_q;   // up to 4096 + 1023 * 80
  logic [48:0] prod_b;
  logic [SUM_W-1:0] sample;

  // Divider state.
  logic [SUM_W-1:0] quo;
  logic [CNT_W:0] rem;
  logic [CNT_W-1:0] dvs;

  logic [16:0] tilt_c;
  logic [BAND_W-1:0] pick_c;
  logic [CNT_W+18:0] tilt_num;
  logic [SUM_W:0] acc_sum;
  logic [CNT_W:0] rem_sh;
  logic [TGT_W-1:0] avg_c;
  logic [TGT_W+32:0] tgt_mul;
  logic [TGT_W-1:0] tgt_c, tgt_q;
  logic [TGT_W:0] lvl_num;
  logic [2*TGT_W+1:0] lvl_mul;
  logic [LVL_W-1:0] lvl_sat;

  always_comb begin
    tilt_num = (CNT_W+19)'(bin_counter) * (CNT_W+19)'(40960);
    tilt_c = 17'(4096 + (tilt_num / NUM_BINS));
    if (bin_counter <= CNT_W'(sub_cutoff)) pick_c = 3'd0;
    else if (bin_counter <= CNT_W'(low_mid_cutoff)) pick_c = 3'd1;
    else if (bin_counter <= CNT_W'(mid_cutoff)) pick_c = 3'd2;
    else if (bin_counter <= CNT_W'(high_mid_cutoff)) pick_c = 3'd3;
    else pick_c = 3'd4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      audio_gain <= 11'd256;
      sub_cutoff <= 9'd3;
      low_mid_cutoff <= 9'd8;
      mid_cutoff <= 9'd23;
      high_mid_cutoff <= 9'd92;
    end else if (cfg_we) begin
      unique case (cfg_req.index)
        REG_GAIN: audio_gain <= cfg_req.data[GAIN_W-1:0];
        REG_SUB: sub_cutoff <= cfg_req.data[CUT_W-1:0];
        REG_LOW_MID: low_mid_cutoff <= cfg_req.data[CUT_W-1:0];
        REG_MID: mid_cutoff <= cfg_req.data[CUT_W-1:0];
        REG_HIGH_MID: high_mid_cutoff <= cfg_req.data[CUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Weighting pipeline: capture, then two registered multiplies.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      idx_q <= bin_counter;
      tilt_q <= tilt_c;
      pick_q <= pick_c;
    end
    if (cmd.mul_a) prod_a <= 32'(in_item.bin_magnitude) * 32'(audio_gain) * 32'd25;
    if (cmd.mul_b) prod_b <= 49'(prod_a) * 49'(tilt_q);
  end

  assign sample = SUM_W'(prod_b >> 20);
  assign acc_sum = (SUM_W+1)'(band_sums[pick_q]) + (SUM_W+1)'(sample);
  assign rem_sh = {rem[CNT_W-1:0], quo[SUM_W-1]};

  // Target: clamp the average, scale by weight/10 with a Q30 multiply.
  // Level: (9 * level + target) / 10 by reciprocal multiply, then saturate.
  always_comb begin
    avg_c = (|quo[SUM_W-1:TGT_W]) ? '1 : quo[TGT_W-1:0];
    tgt_mul = (TGT_W+33)'(avg_c) * (TGT_W+33)'(band_scale(cmd.band));
    tgt_c = (|tgt_mul[TGT_W+32:SCALE_SH+TGT_W]) ? '1
            : tgt_mul[SCALE_SH+TGT_W-1:SCALE_SH];
    lvl_num = (TGT_W+1)'({band_levels[cmd.band], 3'b000})
              + (TGT_W+1)'(band_levels[cmd.band]) + (TGT_W+1)'(tgt_q);
    lvl_mul = (2*TGT_W+2)'(lvl_num) * (2*TGT_W+2)'(RECIP10);
    lvl_sat = (|lvl_mul[2*TGT_W+1:RECIP_SH+LVL_W]) ? LVL_MAX
              : lvl_mul[RECIP_SH+LVL_W-1:RECIP_SH];
  end

  always_ff @(posedge clk) begin
    if (cmd.tgt_calc) tgt_q <= tgt_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_counter <= '0;
      for (int b = 0; b < BANDS; b++) begin
        band_sums[b] <= '0;
        band_counts[b] <= '0;
        band_levels[b] <= '0;
      end
    end else begin
      if (start && !busy && bin_counter != CNT_MAX) bin_counter <= bin_counter + 1'b1;
      if (cmd.acc) begin
        band_sums[pick_q] <= acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
        if (band_counts[pick_q] != CNT_MAX)
          band_counts[pick_q] <= band_counts[pick_q] + 1'b1;
      end
      if (cmd.lvl_calc)
        band_levels[cmd.band] <= lvl_sat;
      if (cmd.clr_frame) begin
        bin_counter <= '0;
        for (int b = 0; b < BANDS; b++) begin
          band_sums[b] <= '0;
          band_counts[b] <= '0;
        end
      end
    end
  end

  // Restoring divider: one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo <= band_sums[cmd.band];
      rem <= '0;
      dvs <= (band_counts[cmd.band] == '0) ? CNT_W'(1) : band_counts[cmd.band];
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= rem_sh - {1'b0, dvs};
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign levels.sub_bass_level = band_levels[0];
  assign levels.low_mid_level = band_levels[1];
  assign levels.mid_level = band_levels[2];
  assign levels.high_mid_level = band_levels[3];
  assign levels.treble_level = band_levels[4];

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.div_step) |-> rem < {1'b0, dvs}) else $error("remainder");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_frame |=> bin_counter == '0) else $error("clear");
  a_idx: assert property (@(posedge clk) disable iff (rst)
    cmd.acc |-> idx_q <= bin_counter) else $error("index");
endmodule

// ===== rtl/core/spectrum_band_level_tracker.sv =====
// Spectrum band level tracker, top level: controller plus datapath.
// A bin passes the two multiply stages and the accumulate; a last bin then adds
// serial division and level update for each band, and its result strobes after.
// New bin requests are taken only while idle, once the last bin is through.
// The 48-step restoring divider, run once per band, fixes the frame-end time.
// Reset (rst, synchronous) restores register defaults, clears sums and levels.
// Results strobe one cycle on done; the receiver cannot stall.
`timescale 1ns / 1ps
module spectrum_band_level_tracker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  sblt_pkg::in_item_t   in_item,
  output logic                 busy,
  output logic                 done,
  output sblt_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  sblt_pkg::cfg_req_t   cfg_req
);
  import sblt_pkg::*;

  cmd_t cmd;
  logic done_c;

  // Configuration is always taken; the user writes only while idle.
  assign cfg_ready = 1'b1;

  sblt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .last_bin(in_item.last_bin),
    .busy(busy), .done(done_c), .cmd(cmd)
  );

  sblt_dp u_dp (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .cfg_we(cfg_valid && cfg_ready), .cfg_req(cfg_req), .cmd(cmd),
    .levels(out_item)
  );

  // Levels update on the last band's edge; done is registered and strobes from that same edge.
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= done_c;
  end
endmodule

// ===== tb/spectrum_band_level_tracker_tb.sv =====
// Testbench for the spectrum band level tracker: drives bin requests and
// register writes, predicts the five smoothed band levels per frame and checks them.
// Depends on sblt_pkg and the spectrum_band_level_tracker RTL.
`timescale 1ns / 1ps

class band_level_scoreboard;
  // Register copies.
  bit [10:0] gain;
  bit [8:0]  cutoff [4];
  // Frame state.
  int unsigned    bin_idx;
  bit [63:0]      sums [5];
  int unsigned    counts [5];
  bit [63:0]      levels [5];
  sblt_pkg::out_item_t level_queue [$];
  int unsigned    errors;

  function new();
    gain = 11'd256;
    cutoff[0] = 9'd3;
    cutoff[1] = 9'd8;
    cutoff[2] = 9'd23;
    cutoff[3] = 9'd92;
    bin_idx = 0;
    errors = 0;
    foreach (sums[b]) begin
      sums[b] = 0;
      counts[b] = 0;
      levels[b] = 0;
    end
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      sblt_pkg::REG_GAIN:     gain = data[10:0];
      sblt_pkg::REG_SUB:      cutoff[0] = data[8:0];
      sblt_pkg::REG_LOW_MID:  cutoff[1] = data[8:0];
      sblt_pkg::REG_MID:      cutoff[2] = data[8:0];
      sblt_pkg::REG_HIGH_MID: cutoff[3] = data[8:0];
      default: ;  // unknown index: drop
    endcase
  endfunction

  // Accumulate one accepted bin; on the last bin queue the new levels.
  function void note_bin(sblt_pkg::in_item_t it);
    bit [63:0] tilt, weighted, avg, target, lvl;
    bit [63:0] wt [5];
    int unsigned band;
    sblt_pkg::out_item_t res;
    wt = '{64'd10, 64'd18, 64'd25, 64'd40, 64'd60};
    tilt = 64'd4096 + (64'd10 * bin_idx * 64'd4096) / sblt_pkg::NUM_BINS;
    weighted = (64'(it.bin_magnitude) * gain * 64'd25 * tilt) >> 20;
    if (bin_idx <= cutoff[0]) band = 0;
    else if (bin_idx <= cutoff[1]) band = 1;
    else if (bin_idx <= cutoff[2]) band = 2;
    else if (bin_idx <= cutoff[3]) band = 3;
    else band = 4;
    sums[band] += weighted;
    if (sums[band] > 64'hFFFF_FFFF_FFFF) sums[band] = 64'hFFFF_FFFF_FFFF;
    if (counts[band] < 1023) counts[band]++;
    if (bin_idx < 1023) bin_idx++;
    if (!it.last_bin) return;
    for (int b = 0; b < 5; b++) begin
      avg = sums[b] / ((counts[b] != 0) ? counts[b] : 1);
      target = (avg * wt[b]) / 10;
      lvl = (64'd9 * levels[b] + target) / 10;
      if (lvl > 64'hFF_FFFF) lvl = 64'hFF_FFFF;
      levels[b] = lvl;
      sums[b] = 0;
      counts[b] = 0;
    end
    bin_idx = 0;
    res.sub_bass_level = levels[0][23:0];
    res.low_mid_level  = levels[1][23:0];
    res.mid_level      = levels[2][23:0];
    res.high_mid_level = levels[3][23:0];
    res.treble_level   = levels[4][23:0];
    level_queue = {level_queue, res};
  endfunction

  function void check_levels(sblt_pkg::out_item_t got);
    sblt_pkg::out_item_t exp_lv;
    if (level_queue.size() == 0) begin
      $display("%0t: unexpected result, got %h", $time, got);
      errors++;
      return;
    end
    exp_lv = level_queue.pop_front();
    if (got.sub_bass_level != exp_lv.sub_bass_level) begin
      $display("%0t: sub_bass_level expected %h got %h", $time,
               exp_lv.sub_bass_level, got.sub_bass_level);
      errors++;
    end
    if (got.low_mid_level != exp_lv.low_mid_level) begin
      $display("%0t: low_mid_level expected %h got %h", $time,
               exp_lv.low_mid_level, got.low_mid_level);
      errors++;
    end
    if (got.mid_level != exp_lv.mid_level) begin
      $display("%0t: mid_level expected %h got %h", $time,
               exp_lv.mid_level, got.mid_level);
      errors++;
    end
    if (got.high_mid_level != exp_lv.high_mid_level) begin
      $display("%0t: high_mid_level expected %h got %h", $time,
               exp_lv.high_mid_level, got.high_mid_level);
      errors++;
    end
    if (got.treble_level != exp_lv.treble_level) begin
      $display("%0t: treble_level expected %h got %h", $time,
               exp_lv.treble_level, got.treble_level);
      errors++;
    end
  endfunction
endclass

module spectrum_band_level_tracker_tb;
  import sblt_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy, done;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_req_t  cfg_req = '0;

  band_level_scoreboard sb = new();
  int unsigned idle_pct;
  int unsigned bins_sent;

  spectrum_band_level_tracker dut (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item), .busy(busy),
    .done(done), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_req(cfg_req)
  );

  always #4 clk = ~clk;

  // Check every strobed result against the oldest predicted level set.
  always @(posedge clk) begin
    if (!rst && done) sb.check_levels(out_item);
  end

  // Send one bin request; optionally idle first. Start stays high into the
  // next request so it is never lowered and raised in the same step.
  task automatic send_bin(logic [15:0] mag, logic last);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= '{bin_magnitude: mag, last_bin: last};
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_bin('{bin_magnitude: mag, last_bin: last});
    bins_sent++;
  endtask

  // Drop start and wait until every predicted frame result has come back,
  // then let the tail of the bin pipeline drain.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.level_queue.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Write one register, then drop valid before returning.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_req <= '{index: idx, data: data};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] g, logic [31:0] c0, logic [31:0] c1,
                           logic [31:0] c2, logic [31:0] c3);
    drain();
    write_reg(REG_GAIN, g);
    write_reg(REG_SUB, c0);
    write_reg(REG_LOW_MID, c1);
    write_reg(REG_MID, c2);
    write_reg(REG_HIGH_MID, c3);
  endtask

  // Random frame of uniform magnitudes, with magnitude corners mixed in.
  task automatic send_frame(int unsigned len);
    logic [15:0] mag;
    for (int unsigned k = 0; k < len; k++) begin
      case ($urandom_range(7))
        0: mag = 16'h0000;
        1: mag = 16'hFFFF;
        default: mag = 16'($urandom);
      endcase
      send_bin(mag, k == len - 1);
    end
  endtask

  initial begin
    int unsigned idle_by_phase [4];
    int unsigned c [4];
    idle_by_phase = '{0, 67, 0, 28};
    idle_pct = 0;
    bins_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: default registers, magnitude extremes, single-bin frame.
    send_bin(16'hFFFF, 1'b0);
    send_bin(16'h0000, 1'b0);
    send_bin(16'h8001, 1'b0);
    send_bin(16'h7FFE, 1'b1);
    send_bin(16'hFFFF, 1'b1);
    // Gain above range, all cutoffs zero: everything past bin 0 is treble.
    write_all(32'd2047, 0, 0, 0, 0);
    for (int k = 0; k < 4; k++) send_bin(16'hFFFF, k == 3);
    // Unordered cutoffs leave the middle bands empty; zero gain.
    write_all(32'd0, 32'd4, 32'd2, 32'd1, 32'd3);
    for (int k = 0; k < 6; k++) send_bin(16'hFFFF, k == 5);
    // Maximum cutoffs, in-range gain ceiling, out-of-list register index.
    write_all(32'd1280, 32'd511, 32'd511, 32'd511, 32'd511);
    write_reg(REG_HIGH_MID + 3'd1, 32'hFFFF_FFFF);
    write_reg(3'(REG_HIGH_MID + 3'd3), 32'h0);
    send_frame(5);
    // Pause until every result is back before the random part.
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_by_phase[ph];
      for (int cfgn = 0; cfgn < 3; cfgn++) begin
        for (int b = 0; b < 4; b++) c[b] = $urandom_range(0, 40);
        c.sort();
        if ($urandom_range(3) == 0) c.shuffle();
        write_all($urandom_range(3) == 0 ? 32'($urandom_range(1281, 2047))
                                          : 32'($urandom_range(0, 1280)),
                  {$urandom} & 32'hFFFF_FE00 | c[0], c[1], c[2], c[3]);
        for (int f = 0; f < 4; f++) send_frame($urandom_range(1, 22));
      end
    end
    // Overlong frame: the bin index saturates; heavy gain saturates levels.
    idle_pct = 0;
    write_all(32'd2047, 32'd511, 32'd20, 32'd30, 32'd40);
    send_frame(1040);
    for (int f = 0; f < 6; f++) send_frame($urandom_range(1, 12));

    drain();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.level_queue.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
